FILE: hw/rtl/pnv_pkg.sv
package pnv_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W = $clog2(CAPACITY + 1);
  localparam int LEN_W = 7;
  localparam int LEN_SAT = 127;
  localparam int STEM_DEPTH = 7;
  localparam int IDX_W = $clog2(STEM_DEPTH);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UTF8_LEAD = 8'hC2;
  localparam logic [7:0] CH_SUP1 = 8'hB9;
  localparam logic [7:0] CH_SUP2 = 8'hB2;
  localparam logic [7:0] CH_SUP3 = 8'hB3;

  typedef logic [STEM_DEPTH-1:0][7:0] stem_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       head0;
    logic [7:0]       head1;
    logic [7:0]       prev;
    logic             dot_seen;
    logic [LEN_W-1:0] trim_len;
    stem_t            stem;
  } comp_state_t;

  function automatic logic [7:0] upper_ascii(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic superscript(input logic [7:0] c);
    return c == CH_SUP1 || c == CH_SUP2 || c == CH_SUP3;
  endfunction

endpackage

FILE: hw/rtl/path_name_validator_unit.sv
// A name byte is registered on acceptance and processed from that register; the
// verdict of a terminator is captured in the output register as it is processed.
// Throughput: one byte per cycle, set by the update of the running state, except that
// a terminator waits behind a held verdict; the output register lets other bytes in.
// Reset (rst, synchronous, active high) clears all running state and both valid flags.
module path_name_validator_unit import pnv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] name_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] name_valid, [7:1] zero
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       fire;
  logic       verdict;
  logic       out_valid;
  logic       out_bit;

  // A terminator can only be processed when the output register is free or draining.
  assign fire = in_valid && (in_byte != CH_NUL || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  pnv_state u_state (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .name_byte (in_byte),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_byte == CH_NUL) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_byte == CH_NUL) begin
      out_bit <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {7'b0, out_bit};

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && in_byte == CH_NUL))
    else $error("verdict without a terminator transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !(fire && in_byte == CH_NUL))
    else $error("terminator processed over a waiting verdict");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_byte))
    else $error("held byte lost while stalled");

endmodule

FILE: hw/rtl/pnv_reserved.sv
module pnv_reserved import pnv_pkg::*; (
  input  comp_state_t comp,
  output logic        reserved
);

  localparam stem_t WORD_CON = {8'h00, 8'h00, 8'h00, 8'h00, "N", "O", "C"};
  localparam stem_t WORD_PRN = {8'h00, 8'h00, 8'h00, 8'h00, "N", "R", "P"};
  localparam stem_t WORD_AUX = {8'h00, 8'h00, 8'h00, 8'h00, "X", "U", "A"};
  localparam stem_t WORD_NUL = {8'h00, 8'h00, 8'h00, 8'h00, "L", "U", "N"};
  localparam stem_t WORD_CONIN = {8'h00, "$", "N", "I", "N", "O", "C"};
  localparam stem_t WORD_CONOUT = {"$", "T", "U", "O", "N", "O", "C"};
  localparam stem_t WORD_CLOCK = {8'h00, "$", "K", "C", "O", "L", "C"};

  function automatic logic word_hit(input stem_t s, input logic [LEN_W-1:0] tlen,
                                    input stem_t w, input int n);
    logic hit;
    hit = (tlen == LEN_W'(n));
    for (int i = 0; i < STEM_DEPTH; i++) begin
      if (i < n && upper_ascii(s[i]) != w[i]) hit = 1'b0;
    end
    return hit;
  endfunction

  logic       word_match;
  logic [7:0] a, b, c, d;
  logic       port_prefix;
  logic       port_match;

  always_comb begin
    word_match = word_hit(comp.stem, comp.trim_len, WORD_CON, 3) ||
                 word_hit(comp.stem, comp.trim_len, WORD_PRN, 3) ||
                 word_hit(comp.stem, comp.trim_len, WORD_AUX, 3) ||
                 word_hit(comp.stem, comp.trim_len, WORD_NUL, 3) ||
                 word_hit(comp.stem, comp.trim_len, WORD_CONIN, 6) ||
                 word_hit(comp.stem, comp.trim_len, WORD_CONOUT, 7) ||
                 word_hit(comp.stem, comp.trim_len, WORD_CLOCK, 6);
    a = upper_ascii(comp.stem[0]);
    b = upper_ascii(comp.stem[1]);
    c = upper_ascii(comp.stem[2]);
    d = comp.stem[3];
    port_prefix = (a == "C" && b == "O" && c == "M") || (a == "L" && b == "P" && c == "T");
    // A port number is one digit from 1 to 9, a Latin-1 superscript, or its two-byte UTF-8 form.
    port_match = 1'b0;
    if (comp.trim_len == LEN_W'(4)) begin
      port_match = (d >= "1" && d <= "9") || superscript(d);
    end else if (comp.trim_len == LEN_W'(5)) begin
      port_match = d == CH_UTF8_LEAD && superscript(comp.stem[4]);
    end
    reserved = word_match || (port_prefix && port_match);
  end

endmodule

FILE: hw/rtl/pnv_state.sv
module pnv_state import pnv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] name_byte,
  output logic       verdict
);

  logic             failed, failed_next;
  logic [POS_W-1:0] position, position_next;
  comp_state_t      comp, comp_next;
  logic             reserved;
  logic             comp_bad;
  logic             is_sep;
  logic             is_illegal;
  logic             is_end;

  pnv_reserved u_reserved (
    .comp     (comp),
    .reserved (reserved)
  );

  always_comb begin
    comp_bad = comp.len == '0 ||
               (comp.len == LEN_W'(1) && comp.head0 == CH_DOT) ||
               (comp.len == LEN_W'(2) && comp.head0 == CH_DOT && comp.head1 == CH_DOT) ||
               comp.prev == CH_DOT || comp.prev == CH_SPACE || reserved;
    verdict = !failed && !comp_bad;
  end

  always_comb begin
    is_end = name_byte == CH_NUL;
    is_sep = name_byte == CH_SLASH || name_byte == CH_BSLASH;
    is_illegal = name_byte < CH_SPACE || name_byte == CH_DEL || name_byte == ":" ||
                 name_byte == "\"" || name_byte == "<" || name_byte == ">" ||
                 name_byte == "|" || name_byte == "?" || name_byte == "*";

    failed_next = failed;
    position_next = position;
    comp_next = comp;
    if (fire) begin
      if (is_end) begin
        failed_next = 1'b0;
        position_next = '0;
        comp_next = '0;
      end else begin
        if (position >= POS_W'(CAPACITY - 1)) failed_next = 1'b1;
        if (position < POS_W'(CAPACITY)) position_next = position + 1'b1;
        if (is_illegal) failed_next = 1'b1;
        if (is_sep) begin
          if (comp_bad) failed_next = 1'b1;
          comp_next = '0;
        end else begin
          if (comp.len == LEN_W'(0)) comp_next.head0 = name_byte;
          if (comp.len == LEN_W'(1)) comp_next.head1 = name_byte;
          if (name_byte == CH_DOT) begin
            comp_next.dot_seen = 1'b1;
          end else if (!comp.dot_seen) begin
            if (comp.len < LEN_W'(STEM_DEPTH)) comp_next.stem[comp.len[IDX_W-1:0]] = name_byte;
            if (name_byte != CH_SPACE) begin
              comp_next.trim_len = (comp.len < LEN_W'(LEN_SAT)) ? comp.len + 1'b1 : comp.len;
            end
          end
          if (comp.len < LEN_W'(LEN_SAT)) comp_next.len = comp.len + 1'b1;
        end
        comp_next.prev = name_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failed <= 1'b0;
      position <= '0;
      comp <= '0;
    end else begin
      failed <= failed_next;
      position <= position_next;
      comp <= comp_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    fire && name_byte == CH_NUL |=> !failed && position == '0 && comp.len == '0)
    else $error("state not cleared after terminator");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed && !(fire && name_byte == CH_NUL) |=> failed)
    else $error("failure flag dropped before terminator");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(CAPACITY))
    else $error("name position beyond capacity");

  a_trim_bound: assert property (@(posedge clk) disable iff (rst)
    comp.trim_len <= comp.len)
    else $error("trimmed stem longer than component");

endmodule
